// ===== rtl/cfce_pkg.sv =====
// ----------------------------------------------------------------------------
// cfce_pkg
// Shared types and constants for the FAT cluster chain extents block.
// ----------------------------------------------------------------------------
package cfce_pkg;

    // result codes
    typedef enum logic [1:0] {
        KIND_FETCH  = 2'd0,
        KIND_EXTENT = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_LOOP   = 2'd3
    } kind_t;

    // input function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_WORD  = 1'b1;

    // fat_kind register codes
    localparam logic [1:0] FAT12 = 2'd0;
    localparam logic [1:0] FAT16 = 2'd1;

    // register indexes
    localparam logic REG_FAT_KIND = 1'b0;
    localparam logic REG_DCC      = 1'b1;

    localparam int CFG_DATA_W = 28;

    // end-of-chain marks
    localparam logic [31:0] END_FAT12 = 32'h0000_0FF8;
    localparam logic [31:0] END_FAT16 = 32'h0000_FFF8;
    localparam logic [31:0] END_FAT32 = 32'h0FFF_FFF8;

    localparam int QUEUE_DEPTH_DEF = 4;

    // work for the back end: an optional closed extent plus one final result
    typedef struct packed {
        logic        has_extent;
        logic [27:0] ext_start;
        logic [28:0] ext_vcn;
        kind_t       final_kind;
        logic [29:0] fetch_offset;
        logic [28:0] total;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

endpackage

// ===== rtl/cfce_front.sv =====
// ----------------------------------------------------------------------------
// cfce_front
// Takes items, decodes FAT words, classifies clusters and keeps chain state.
// ----------------------------------------------------------------------------
module cfce_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic                            wr_index,
    input  logic [cfce_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                            accept,
    input  logic                            func,
    input  logic [31:0]                     value,
    output logic                            cmd_valid,
    output cfce_pkg::cmd_t                  cmd
);

    logic [1:0]  fat_kind_reg;
    logic [27:0] dcc_reg;
    logic [27:0] run_first_reg, run_first_next;
    logic [27:0] run_prev_reg, run_prev_next;
    logic [28:0] vcn_sum_reg, vcn_sum_next;
    logic [28:0] tally_reg, tally_next;
    logic        active_reg, active_next;

    logic [27:0] base_first, base_prev;
    logic [28:0] base_vcn, base_tally;
    logic [31:0] clus, end_mark;
    logic [28:0] limit, run_len, vcn_close, tally_inc;
    logic [27:0] clus28;
    logic        bad, open_run, contig, loop_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fat_kind_reg  <= cfce_pkg::FAT12;
            dcc_reg       <= 28'd1;
            run_first_reg <= '0;
            run_prev_reg  <= '0;
            vcn_sum_reg   <= '0;
            tally_reg     <= '0;
            active_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == cfce_pkg::REG_FAT_KIND)
                    fat_kind_reg <= wr_data[1:0];
                else
                    dcc_reg <= wr_data;
            end
            run_first_reg <= run_first_next;
            run_prev_reg  <= run_prev_next;
            vcn_sum_reg   <= vcn_sum_next;
            tally_reg     <= tally_next;
            active_reg    <= active_next;
        end
    end

    always_comb
    begin
        // a start item works from a cleared chain
        if (func == cfce_pkg::FUNC_START)
        begin
            base_first = '0;
            base_prev  = '0;
            base_vcn   = '0;
            base_tally = '0;
            clus       = value;
        end
        else
        begin
            base_first = run_first_reg;
            base_prev  = run_prev_reg;
            base_vcn   = vcn_sum_reg;
            base_tally = tally_reg;
            case (fat_kind_reg)
                cfce_pkg::FAT12:
                    clus = run_prev_reg[0] ? {20'd0, value[15:4]} : {20'd0, value[11:0]};
                cfce_pkg::FAT16:
                    clus = {16'd0, value[15:0]};
                default:
                    clus = {4'd0, value[27:0]};
            endcase
        end

        case (fat_kind_reg)
            cfce_pkg::FAT12: end_mark = cfce_pkg::END_FAT12;
            cfce_pkg::FAT16: end_mark = cfce_pkg::END_FAT16;
            default:         end_mark = cfce_pkg::END_FAT32;
        endcase

        limit     = {1'b0, dcc_reg} + 29'd1;
        clus28    = clus[27:0];
        bad       = (clus >= end_mark) || (clus < 32'd2) || (clus > {3'd0, limit});
        open_run  = (base_prev != '0);
        contig    = open_run && ({1'b0, clus28} == ({1'b0, base_prev} + 29'd1));
        run_len   = {1'b0, base_prev} - {1'b0, base_first} + 29'd1;
        vcn_close = base_vcn + run_len;
        tally_inc = base_tally + 29'd1;
        loop_hit  = (tally_inc >= limit);

        cmd_valid      = accept && ((func == cfce_pkg::FUNC_START) || active_reg);
        run_first_next = run_first_reg;
        run_prev_next  = run_prev_reg;
        vcn_sum_next   = vcn_sum_reg;
        tally_next     = tally_reg;
        active_next    = active_reg;

        cmd.ext_start    = base_first - 28'd2;
        cmd.ext_vcn      = vcn_close;
        cmd.fetch_offset = '0;

        if (bad)
        begin
            cmd.has_extent = open_run;
            cmd.final_kind = cfce_pkg::KIND_FINISH;
            cmd.total      = base_tally;
        end
        else
        begin
            cmd.has_extent = open_run && !contig;
            cmd.final_kind = loop_hit ? cfce_pkg::KIND_LOOP : cfce_pkg::KIND_FETCH;
            cmd.total      = tally_inc;
            if (!loop_hit)
            begin
                case (fat_kind_reg)
                    cfce_pkg::FAT12:
                        cmd.fetch_offset = {2'd0, clus28} + {3'd0, clus28[27:1]};
                    cfce_pkg::FAT16:
                        cmd.fetch_offset = {1'b0, clus28, 1'b0};
                    default:
                        cmd.fetch_offset = {clus28, 2'b00};
                endcase
            end
        end

        if (cmd_valid)
        begin
            if (bad)
            begin
                run_first_next = base_first;
                run_prev_next  = base_prev;
                vcn_sum_next   = open_run ? vcn_close : base_vcn;
                tally_next     = base_tally;
                active_next    = 1'b0;
            end
            else
            begin
                run_first_next = contig ? base_first : clus28;
                run_prev_next  = clus28;
                vcn_sum_next   = (open_run && !contig) ? vcn_close : base_vcn;
                tally_next     = tally_inc;
                active_next    = !loop_hit;
            end
        end
    end

    a_loop_stops: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && (cmd.final_kind == cfce_pkg::KIND_LOOP) |=> !active_reg)
        else $error("chain still active after loop error");

    a_word_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func == cfce_pkg::FUNC_WORD) && !active_reg |-> !cmd_valid)
        else $error("fat word taken while idle");

    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (run_prev_reg >= run_first_reg))
        else $error("open run ends before it starts");

endmodule

// ===== rtl/cfce_queue.sv =====
// ----------------------------------------------------------------------------
// cfce_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module cfce_queue
#(
    parameter int DEPTH = cfce_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           enq,
    input  cfce_pkg::cmd_t enq_cmd,
    input  logic           deq,
    output logic           full,
    output cfce_pkg::head_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cfce_pkg::cmd_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_deq;

    assign do_deq     = deq && (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (enq && !full)
            mem[wr_ptr_reg] <= enq_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (enq && !full)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_deq)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            case ({enq && !full, do_deq})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count past depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        enq && !full && !do_deq |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue lost an item");

endmodule

// ===== rtl/cfce_back.sv =====
// ----------------------------------------------------------------------------
// cfce_back
// Turns each queued command into one or two results for the output side.
// ----------------------------------------------------------------------------
module cfce_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfce_pkg::head_t head,
    output logic            deq,
    input  logic            pop,
    output logic            empty,
    output logic [1:0]      kind,
    output logic [27:0]     extent_start,
    output logic [28:0]     extent_next_vcn,
    output logic [29:0]     fetch_offset,
    output logic [28:0]     total_clusters,
    output logic            last
);

    logic sel_reg, sel_next;
    logic ext_phase;

    // the extent goes out first when there is one
    assign ext_phase = head.cmd.has_extent && !sel_reg;

    always_comb
    begin
        empty          = !head.valid;
        total_clusters = head.cmd.total;
        if (ext_phase)
        begin
            kind            = cfce_pkg::KIND_EXTENT;
            extent_start    = head.cmd.ext_start;
            extent_next_vcn = head.cmd.ext_vcn;
            fetch_offset    = '0;
            last            = 1'b0;
        end
        else
        begin
            kind            = head.cmd.final_kind;
            extent_start    = '0;
            extent_next_vcn = '0;
            fetch_offset    = head.cmd.fetch_offset;
            last            = 1'b1;
        end

        deq      = 1'b0;
        sel_next = sel_reg;
        if (pop && head.valid)
        begin
            if (ext_phase)
                sel_next = 1'b1;
            else
            begin
                deq      = 1'b1;
                sel_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else
            sel_reg <= sel_next;
    end

    a_sel_needs_ext: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> head.valid && head.cmd.has_extent)
        else $error("second half selected without extent");

endmodule

// ===== rtl/fat_cluster_chain_extents_top.sv =====
// ----------------------------------------------------------------------------
// fat_cluster_chain_extents_top
// Walks FAT12/16/32 cluster chains and reports extents and fetch offsets.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// input     in         push / full               func, value
// result    out        pop / empty               kind, extent_start,
//                                                extent_next_vcn, fetch_offset,
//                                                total_clusters, last
// config    in         wr_en                     wr_index, wr_data
//
// one item accepted per cycle while full is low; the front decodes it, updates
// chain state and queues a command of one or two results (none for a word taken
// while idle). results leave at one per cycle while pop is high and empty is low;
// an item that closes an extent gives two. full rises once QUEUE_DEPTH commands wait.
// reset empties the queue and clears chain state; no clearing pass.
// ----------------------------------------------------------------------------
module fat_cluster_chain_extents_top
#(
    parameter int QUEUE_DEPTH = cfce_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic                            wr_index,
    input  logic [cfce_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic                            push,
    output logic                            full,
    input  logic                            func,
    input  logic [31:0]                     value,
    input  logic                            pop,
    output logic                            empty,
    output logic [1:0]                      kind,
    output logic [27:0]                     extent_start,
    output logic [28:0]                     extent_next_vcn,
    output logic [29:0]                     fetch_offset,
    output logic [28:0]                     total_clusters,
    output logic                            last
);

    logic            accept;
    logic            cmd_valid;
    logic            deq;
    cfce_pkg::cmd_t  cmd;
    cfce_pkg::head_t head;

    assign accept = push && !full;

    cfce_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .accept    (accept),
        .func      (func),
        .value     (value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    cfce_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .enq     (cmd_valid),
        .enq_cmd (cmd),
        .deq     (deq),
        .full    (full),
        .head    (head)
    );

    cfce_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .deq             (deq),
        .pop             (pop),
        .empty           (empty),
        .kind            (kind),
        .extent_start    (extent_start),
        .extent_next_vcn (extent_next_vcn),
        .fetch_offset    (fetch_offset),
        .total_clusters  (total_clusters),
        .last            (last)
    );

endmodule

// ===== sim/fat_cluster_chain_extents_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_chain_extents_top_test
// Self-checking bench for the FAT cluster chain walker. A short table of
// directed items, some with hand-computed results, is followed by random
// chains under many register settings. Every item accepted on the input side
// is run through a local model of the chain walk, and the results that
// come back are compared field by field in order.
// ----------------------------------------------------------------------------
module fat_cluster_chain_extents_top_test;

    localparam logic [1:0] FAT32     = 2'd2;
    localparam logic [1:0] FAT_SPARE = 2'd3;

    localparam int          RANDOM_ITEMS  = 1850;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          LONG_STALL    = 160;
    localparam int          TIMEOUT_NS    = 1_000_000;
    localparam logic [27:0] DCC_MAX       = 28'd268435445;

    typedef struct packed {
        cfce_pkg::kind_t kind;
        logic [27:0]     extent_start;
        logic [28:0]     extent_next_vcn;
        logic [29:0]     fetch_offset;
        logic [28:0]     total_clusters;
        logic            last;
    } chain_result_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_SETTING
    } row_op_t;

    typedef struct packed {
        row_op_t       op;
        logic          cfg_index;
        logic          f;
        logic [31:0]   v;
        logic [1:0]    n_typed;
        chain_result_t r0;
        chain_result_t r1;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic        wr_index;
    logic [27:0] wr_data;
    logic        push;
    logic        full;
    logic        func;
    logic [31:0] value;
    logic        pop;
    logic        empty;
    logic [1:0]  kind;
    logic [27:0] extent_start;
    logic [28:0] extent_next_vcn;
    logic [29:0] fetch_offset;
    logic [28:0] total_clusters;
    logic        last;

    // local copy of the registers and the chain state
    logic [1:0]  cfg_fat_kind;
    logic [27:0] cfg_cluster_count;
    logic [27:0] ext_first;
    logic [27:0] ext_prev;
    logic [28:0] vcn_acc;
    logic [28:0] cluster_count;
    logic [28:0] visit_count;
    logic        walking;

    chain_result_t pending_chain_results [$];
    stim_row_t     directed_rows [$];

    int errors        = 0;
    int results_seen  = 0;
    int random_items  = 0;
    int settings_used = 0;
    int kind_tally [4] = '{0, 0, 0, 0};

    fat_cluster_chain_extents_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .push            (push),
        .full            (full),
        .func            (func),
        .value           (value),
        .pop             (pop),
        .empty           (empty),
        .kind            (kind),
        .extent_start    (extent_start),
        .extent_next_vcn (extent_next_vcn),
        .fetch_offset    (fetch_offset),
        .total_clusters  (total_clusters),
        .last            (last)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

    function automatic chain_result_t mk_result(cfce_pkg::kind_t k, logic [27:0] s,
                                                logic [28:0] nv, logic [29:0] off,
                                                logic [28:0] tot, logic lst);
        chain_result_t r;
        r.kind            = k;
        r.extent_start    = s;
        r.extent_next_vcn = nv;
        r.fetch_offset    = off;
        r.total_clusters  = tot;
        r.last            = lst;
        return r;
    endfunction

    function automatic stim_row_t row_item(logic f, logic [31:0] v);
        stim_row_t r;
        r         = '0;
        r.op      = ROW_ITEM;
        r.f       = f;
        r.v       = v;
        return r;
    endfunction

    function automatic stim_row_t row_typed(logic f, logic [31:0] v, logic [1:0] n,
                                            chain_result_t a, chain_result_t b);
        stim_row_t r;
        r         = row_item(f, v);
        r.n_typed = n;
        r.r0      = a;
        r.r1      = b;
        return r;
    endfunction

    function automatic stim_row_t row_setting(logic idx, logic [27:0] data);
        stim_row_t r;
        r           = '0;
        r.op        = ROW_SETTING;
        r.cfg_index = idx;
        r.v         = {4'd0, data};
        return r;
    endfunction

    function automatic logic [31:0] end_mark_of(logic [1:0] fk);
        if (fk == cfce_pkg::FAT12)
            return cfce_pkg::END_FAT12;
        if (fk == cfce_pkg::FAT16)
            return cfce_pkg::END_FAT16;
        return cfce_pkg::END_FAT32;
    endfunction

    // closes the open run and adds its length to the running vcn
    function automatic chain_result_t close_extent();
        vcn_acc = vcn_acc + {1'b0, ext_prev} - {1'b0, ext_first} + 29'd1;
        return mk_result(cfce_pkg::KIND_EXTENT, ext_first - 28'd2, vcn_acc, '0,
                         cluster_count, 1'b0);
    endfunction

    task automatic walk_chain_item(input logic f, input logic [31:0] v,
                                   output chain_result_t r0, output chain_result_t r1,
                                   output int n);
        chain_result_t got [2];
        logic [31:0]   c;
        logic [31:0]   limit;
        logic [31:0]   off;
        n      = 0;
        got[0] = '0;
        got[1] = '0;
        if (f == cfce_pkg::FUNC_START)
        begin
            ext_first     = '0;
            ext_prev      = '0;
            vcn_acc       = '0;
            cluster_count = '0;
            visit_count   = '0;
            walking       = 1'b1;
            c             = v;
        end
        else if (cfg_fat_kind == cfce_pkg::FAT12)
            c = ext_prev[0] ? {20'd0, v[15:4]} : {20'd0, v[11:0]};
        else if (cfg_fat_kind == cfce_pkg::FAT16)
            c = {16'd0, v[15:0]};
        else
            c = {4'd0, v[27:0]};
        if (walking)
        begin
            limit = {4'd0, cfg_cluster_count} + 32'd1;
            if (c >= end_mark_of(cfg_fat_kind) || c < 32'd2 || c > limit)
            begin
                if (ext_prev != '0)
                begin
                    got[n] = close_extent();
                    n++;
                end
                got[n] = mk_result(cfce_pkg::KIND_FINISH, '0, '0, '0, cluster_count, 1'b0);
                n++;
                walking = 1'b0;
            end
            else
            begin
                cluster_count = cluster_count + 29'd1;
                if (ext_prev == '0)
                    ext_first = c[27:0];
                else if (c != {4'd0, ext_prev} + 32'd1)
                begin
                    got[n]    = close_extent();
                    n++;
                    ext_first = c[27:0];
                end
                ext_prev    = c[27:0];
                visit_count = visit_count + 29'd1;
                if ({3'd0, visit_count} >= limit)
                begin
                    // loop limit: open run is dropped
                    got[n]  = mk_result(cfce_pkg::KIND_LOOP, '0, '0, '0, cluster_count, 1'b0);
                    walking = 1'b0;
                end
                else
                begin
                    if (cfg_fat_kind == cfce_pkg::FAT12)
                        off = c + (c >> 1);
                    else if (cfg_fat_kind == cfce_pkg::FAT16)
                        off = c << 1;
                    else
                        off = c << 2;
                    got[n] = mk_result(cfce_pkg::KIND_FETCH, '0, '0, off[29:0],
                                       cluster_count, 1'b0);
                end
                n++;
            end
            got[n-1].last = 1'b1;
        end
        r0 = got[0];
        r1 = got[1];
    endtask

    task automatic send_item(input logic f, input logic [31:0] v, input logic [1:0] n_typed,
                             input chain_result_t t0, input chain_result_t t1,
                             output int n);
        chain_result_t p0;
        chain_result_t p1;
        int            gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        func  <= f;
        value <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        walk_chain_item(f, v, p0, p1, n);
        if (n_typed != 0)
        begin
            n  = n_typed;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            pending_chain_results.push_back(p0);
        if (n > 1)
            pending_chain_results.push_back(p1);
    endtask

    // registers change only with nothing in flight
    task automatic apply_setting(input logic idx, input logic [27:0] data);
        push <= 1'b0;
        @(posedge clk);
        while (pending_chain_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == cfce_pkg::REG_FAT_KIND)
            cfg_fat_kind = data[1:0];
        else
            cfg_cluster_count = data;
    endtask

    // mostly well-formed chains: the next word points at a cluster drawn
    // from continue / jump / revisit / end mark / out of range
    task automatic pick_item(output logic f, output logic [31:0] v);
        logic [31:0] mark;
        logic [31:0] limit;
        logic [31:0] top;
        logic [31:0] next_c;
        int          roll;
        int          pick;
        mark  = end_mark_of(cfg_fat_kind);
        limit = {4'd0, cfg_cluster_count} + 32'd1;
        top   = (limit < mark) ? limit : mark - 32'd1;
        roll  = $urandom_range(0, 99);
        if (!walking && roll < 5)
        begin
            f = cfce_pkg::FUNC_WORD;
            v = $urandom;
        end
        else if (!walking || roll < 3)
        begin
            f    = cfce_pkg::FUNC_START;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                v = 32'd0;
            else if (pick == 1)
                v = 32'd1;
            else if (pick == 2)
                v = $urandom;
            else if (pick == 3)
                v = $urandom_range(mark | 32'h7, mark);
            else
                v = $urandom_range(top, 2);
        end
        else if (roll < 9)
        begin
            f = cfce_pkg::FUNC_WORD;
            v = $urandom;
        end
        else
        begin
            f = cfce_pkg::FUNC_WORD;
            if (roll < 55)
                next_c = {4'd0, ext_prev} + 32'd1;
            else if (roll < 70)
                next_c = $urandom_range(top, 2);
            else if (roll < 75)
                next_c = {4'd0, ext_prev};
            else if (roll < 86)
                next_c = $urandom_range(mark | 32'h7, mark);
            else if (roll < 94 && top < mark - 32'd1)
                next_c = $urandom_range(mark - 32'd1, top + 32'd1);
            else
                next_c = $urandom_range(1, 0);
            // unused bits of the word stay random
            v = $urandom;
            if (cfg_fat_kind == cfce_pkg::FAT12)
            begin
                if (ext_prev[0])
                    v[15:4] = next_c[11:0];
                else
                    v[11:0] = next_c[11:0];
            end
            else if (cfg_fat_kind == cfce_pkg::FAT16)
                v[15:0] = next_c[15:0];
            else
                v[27:0] = next_c[27:0];
        end
    endtask

    initial
    begin : result_sink
        chain_result_t want;
        int            stall;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            // long hold-offs let the input side fill the block up
            if (results_seen % 500 == 250)
                stall = LONG_STALL;
            else
                stall = $urandom_range(0, 3);
            if (stall != 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            results_seen++;
            kind_tally[kind]++;
            if (pending_chain_results.size() == 0)
            begin
                $error("result with no item pending: kind %0d", kind);
                errors++;
            end
            else
            begin
                want = pending_chain_results.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind mismatch: expected %0d, actual %0d", want.kind, kind);
                    errors++;
                end
                if (extent_start !== want.extent_start)
                begin
                    $error("extent_start mismatch: expected %0d, actual %0d",
                           want.extent_start, extent_start);
                    errors++;
                end
                if (extent_next_vcn !== want.extent_next_vcn)
                begin
                    $error("extent_next_vcn mismatch: expected %0d, actual %0d",
                           want.extent_next_vcn, extent_next_vcn);
                    errors++;
                end
                if (fetch_offset !== want.fetch_offset)
                begin
                    $error("fetch_offset mismatch: expected %0d, actual %0d",
                           want.fetch_offset, fetch_offset);
                    errors++;
                end
                if (total_clusters !== want.total_clusters)
                begin
                    $error("total_clusters mismatch: expected %0d, actual %0d",
                           want.total_clusters, total_clusters);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last mismatch: expected %0d, actual %0d", want.last, last);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic        f;
        logic [31:0] v;
        logic [1:0]  fk;
        logic [27:0] dcc;
        int          n;
        int          phase_len;
        int          pick;
        rst_n    <= 1'b0;
        push     <= 1'b0;
        func     <= cfce_pkg::FUNC_START;
        value    <= '0;
        wr_en    <= 1'b0;
        wr_index <= cfce_pkg::REG_FAT_KIND;
        wr_data  <= '0;
        cfg_fat_kind      = cfce_pkg::FAT12;
        cfg_cluster_count = 28'd1;
        ext_first         = '0;
        ext_prev          = '0;
        vcn_acc           = '0;
        cluster_count     = '0;
        visit_count       = '0;
        walking           = 1'b0;

        // reset defaults: FAT12, one data cluster, highest cluster 2
        directed_rows.push_back(row_typed(cfce_pkg::FUNC_START, 32'd0, 2'd1,
            mk_result(cfce_pkg::KIND_FINISH, '0, '0, '0, '0, 1'b1), '0));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_WORD, 32'h0000_0123));
        directed_rows.push_back(row_typed(cfce_pkg::FUNC_START, 32'd2, 2'd1,
            mk_result(cfce_pkg::KIND_FETCH, '0, '0, 30'd3, 29'd1, 1'b1), '0));
        // revisit of cluster 2 trips the loop limit, the closed run still goes out
        directed_rows.push_back(row_typed(cfce_pkg::FUNC_WORD, 32'hFFFF_F002, 2'd2,
            mk_result(cfce_pkg::KIND_EXTENT, '0, 29'd1, '0, 29'd2, 1'b0),
            mk_result(cfce_pkg::KIND_LOOP, '0, '0, '0, 29'd2, 1'b1)));
        directed_rows.push_back(row_typed(cfce_pkg::FUNC_START, 32'd1, 2'd1,
            mk_result(cfce_pkg::KIND_FINISH, '0, '0, '0, '0, 1'b1), '0));
        directed_rows.push_back(row_typed(cfce_pkg::FUNC_START, 32'hFFFF_FFFF, 2'd1,
            mk_result(cfce_pkg::KIND_FINISH, '0, '0, '0, '0, 1'b1), '0));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_WORD, 32'h0000_0005));
        directed_rows.push_back(row_setting(cfce_pkg::REG_DCC, 28'd100));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_START, 32'd3));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_WORD, 32'hABCD_004F));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_WORD, 32'hFFFF_F005));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_WORD, 32'h0000_00A0));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_WORD, 32'h0000_0FFF));
        // restart while a chain is open
        directed_rows.push_back(row_item(cfce_pkg::FUNC_START, 32'd5));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_START, 32'd7));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_WORD, 32'h0000_FF80));
        directed_rows.push_back(row_setting(cfce_pkg::REG_FAT_KIND, {26'd0, cfce_pkg::FAT16}));
        directed_rows.push_back(row_setting(cfce_pkg::REG_DCC, 28'd65524));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_START, 32'h0000_FFF5));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_WORD, 32'h1234_FFF6));
        directed_rows.push_back(row_setting(cfce_pkg::REG_FAT_KIND, {26'd0, FAT32}));
        directed_rows.push_back(row_setting(cfce_pkg::REG_DCC, DCC_MAX));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_START, 32'h0FFF_FFF6));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_WORD, 32'hF000_0002));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_WORD, 32'hFFFF_FFFF));
        // spare code decodes like FAT32
        directed_rows.push_back(row_setting(cfce_pkg::REG_FAT_KIND, {26'd0, FAT_SPARE}));
        directed_rows.push_back(row_setting(cfce_pkg::REG_DCC, 28'd1));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_START, 32'd2));
        directed_rows.push_back(row_item(cfce_pkg::FUNC_WORD, 32'h0FFF_FFF8));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == ROW_SETTING)
                apply_setting(directed_rows[i].cfg_index, directed_rows[i].v[27:0]);
            else
                send_item(directed_rows[i].f, directed_rows[i].v, directed_rows[i].n_typed,
                          directed_rows[i].r0, directed_rows[i].r1, n);
        end

        while (random_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            fk   = (pick == 9) ? FAT_SPARE : 2'(pick % 3);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                dcc = 28'd1;
            else if (pick == 1)
                dcc = DCC_MAX;
            else if (pick == 2)
                dcc = (fk == cfce_pkg::FAT12) ? 28'd4084 :
                      (fk == cfce_pkg::FAT16) ? 28'd65524 : 28'($urandom_range(DCC_MAX, 1));
            else
                dcc = 28'($urandom_range(48, 2));
            apply_setting(cfce_pkg::REG_FAT_KIND, {26'd0, fk});
            apply_setting(cfce_pkg::REG_DCC, dcc);
            settings_used++;
            phase_len = $urandom_range(30, 90);
            for (int k = 0; k < phase_len; k++)
            begin
                // now and then the input side waits for the output to run dry
                if (k == phase_len / 2 && settings_used % 4 == 0)
                begin
                    push <= 1'b0;
                    @(posedge clk);
                    while (pending_chain_results.size() != 0)
                        @(posedge clk);
                end
                pick_item(f, v);
                send_item(f, v, 2'd0, '0, '0, n);
                if (n > 0)
                    random_items++;
            end
        end

        push <= 1'b0;
        @(posedge clk);
        while (pending_chain_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results from %0d directed rows and %0d random items, %0d settings",
                 results_seen, directed_rows.size(), random_items, settings_used);
        $display("result mix: %0d fetch, %0d extent, %0d finish, %0d loop",
                 kind_tally[cfce_pkg::KIND_FETCH], kind_tally[cfce_pkg::KIND_EXTENT],
                 kind_tally[cfce_pkg::KIND_FINISH], kind_tally[cfce_pkg::KIND_LOOP]);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
